[hdl/pdtp_pkg.sv]
// ----------------------------------------------------------------------------
// pdtp_pkg: shared types and constants of the pad / text packetizer
// Sizes, frame bytes, request codes, state encoding and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pdtp_pkg;

    // Sizes
    localparam int PAD_COUNT   = 64;   // 1..64
    localparam int LINE_COUNT  = 4;    // 1..4
    localparam int LINE_LEN    = 68;
    localparam int LANES       = 3;    // characters per frame word
    localparam int GROUPS      = 24;   // text rows per display line
    localparam int FLUSH_WORDS = 26;

    localparam int PAD_AW    = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam int TXT_DEPTH = LINE_COUNT * GROUPS;
    localparam int TXT_AW    = $clog2(TXT_DEPTH);
    localparam int WORD_W    = $clog2(FLUSH_WORDS + 1);

    localparam logic [6:0] PAD_LIMIT  = 7'(PAD_COUNT);
    localparam logic [2:0] LINE_LIMIT = 3'(LINE_COUNT);
    localparam logic [1:0] LAST_LINE  = 2'(LINE_COUNT - 1);
    localparam logic [7:0] COL_LIMIT  = 8'(LINE_LEN);

    // Frame bytes
    localparam logic [7:0] B_PAD_BASE  = 8'h24;
    localparam logic [7:0] B_SYSEX     = 8'h04;
    localparam logic [7:0] B_SYSEX_END = 8'h06;
    localparam logic [7:0] B_START     = 8'hf0;
    localparam logic [7:0] B_MAKER     = 8'h47;
    localparam logic [7:0] B_MODEL     = 8'h7f;
    localparam logic [7:0] B_MSG_ID    = 8'h15;
    localparam logic [7:0] B_LINE_BASE = 8'h18;
    localparam logic [7:0] B_LEN       = 8'h45;
    localparam logic [7:0] B_END       = 8'hf7;
    localparam logic [7:0] B_SPACE     = 8'h20;
    localparam logic [7:0] B_ERASE     = 8'hff;
    localparam logic [7:0] B_ZERO      = 8'h00;
    localparam logic [7:0] B_ASCII_MAX = 8'h7f;

    // Reciprocal of 3 for column grouping: (j * 43) >> 7, exact for j < 128
    localparam logic [5:0] RECIP3 = 6'd43;

    // Register map
    localparam logic REG_CLEAR_CODE = 1'b0;

    typedef enum logic [1:0] {
        REQ_PAD    = 2'd0,
        REQ_CHAR   = 2'd1,
        REQ_FLUSH  = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PAD_OUT,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic take;         // input transfer accepted
        logic chr_commit;   // store the character
        logic flush_start;  // start a line frame
        logic pad_load;     // load pad word and record pad values
        logic word_load;    // load next frame word
    } t_dp_cmd;

    typedef struct packed {
        logic clearing;     // text store clear pass running
        t_req req_kind;
        logic pad_emit;
        logic chr_ok;
        logic flush_ok;
        logic out_free;
        logic word_last;
    } t_dp_stat;

    function automatic logic [31:0] pack4(logic [7:0] b0, logic [7:0] b1,
                                          logic [7:0] b2, logic [7:0] b3);
        return {b3, b2, b1, b0};
    endfunction

    function automatic logic [7:0] sanitize(logic [7:0] c);
        logic [7:0] r;
        if (c == B_ERASE) begin
            r = B_ZERO;
        end else if (c > B_ASCII_MAX) begin
            r = B_SPACE;
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

[hdl/pdtp_ctrl.sv]
// ----------------------------------------------------------------------------
// pdtp_ctrl: request sequencer
// Takes one request at a time, lets the datapath decide, then walks the
// pad word or the 26 frame words out through the output register.
// ----------------------------------------------------------------------------
module pdtp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  pdtp_pkg::t_dp_stat i_stat,
    output pdtp_pkg::t_dp_cmd  o_cmd
);
    import pdtp_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid && !i_stat.clearing) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_stat.req_kind == REQ_PAD && i_stat.pad_emit) begin
                    n_state = ST_PAD_OUT;
                end else if (i_stat.req_kind == REQ_FLUSH && i_stat.flush_ok) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (i_stat.out_free && i_stat.word_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready  = !i_stat.clearing;
                o_cmd.take = i_s_valid && !i_stat.clearing;
            end
            ST_EXEC: begin
                o_cmd.chr_commit  = (i_stat.req_kind == REQ_CHAR) && i_stat.chr_ok;
                o_cmd.flush_start = (i_stat.req_kind == REQ_FLUSH) && i_stat.flush_ok;
            end
            ST_PAD_OUT: begin
                o_cmd.pad_load = i_stat.out_free;
            end
            ST_FLUSH: begin
                o_cmd.word_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Checks
    a_take_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> r_state == ST_EXEC)
        else $error("accepted request not followed by decode");

    a_flush_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.word_load && i_stat.word_last) |=> r_state == ST_IDLE)
        else $error("frame did not end after its last word");

    a_pad_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PAD_OUT |-> i_stat.req_kind == REQ_PAD)
        else $error("pad output for a request that is not a pad update");

endmodule

[hdl/pdtp_datapath.sv]
// ----------------------------------------------------------------------------
// pdtp_datapath: pad shadow store, text store and output register
// Holds the request, the last sent pad values, the display text in three
// byte lanes (one frame word per row) and builds the output words.
// ----------------------------------------------------------------------------
module pdtp_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pdtp_pkg::t_dp_cmd  i_cmd,
    output pdtp_pkg::t_dp_stat o_stat,
    input  logic [7:0]         i_clear_code,
    input  logic [1:0]         i_req_type,
    input  logic [5:0]         i_pad_index,
    input  logic [7:0]         i_pad_color,
    input  logic [7:0]         i_pad_blink,
    input  logic [7:0]         i_pad_status,
    input  logic [1:0]         i_text_line,
    input  logic [6:0]         i_text_column,
    input  logic [7:0]         i_text_char,
    input  logic               i_m_ready,
    output logic               o_m_valid,
    output logic [31:0]        o_m_data,
    output logic               o_m_last
);
    import pdtp_pkg::*;

    // Request register
    logic [1:0] r_type;
    logic [5:0] r_pad;
    logic [7:0] r_color;
    logic [7:0] r_blink;
    logic [7:0] r_status;
    logic [1:0] r_line;
    logic [6:0] r_col;
    logic [7:0] r_char;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_type   <= i_req_type;
            r_pad    <= i_pad_index;
            r_color  <= i_pad_color;
            r_blink  <= i_pad_blink;
            r_status <= i_pad_status;
            r_line   <= i_text_line;
            r_col    <= i_text_column;
            r_char   <= i_text_char;
        end
    end

    // Pad shadow store: {color, blink, status}, read on accept
    logic [23:0] r_pad_mem [PAD_COUNT];
    logic [23:0] r_pad_rd;
    logic        r_sent_valid [PAD_COUNT];
    logic [PAD_AW-1:0] pad_idx;
    logic [7:0]  color_m;
    logic        pad_in_range;
    logic        pad_same;

    assign pad_idx      = r_pad[PAD_AW-1:0];
    assign color_m      = (r_color == i_clear_code) ? B_ZERO : r_color;
    assign pad_in_range = {1'b0, r_pad} < PAD_LIMIT;
    assign pad_same     = r_sent_valid[pad_idx] && (r_pad_rd == {color_m, r_blink, r_status});

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pad_rd <= r_pad_mem[i_pad_index[PAD_AW-1:0]];
        end
        if (i_cmd.pad_load) begin
            r_pad_mem[pad_idx] <= {color_m, r_blink, r_status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PAD_COUNT; p++) begin
                r_sent_valid[p] <= 1'b0;
            end
        end else if (i_cmd.pad_load) begin
            r_sent_valid[pad_idx] <= 1'b1;
        end
    end

    // Text placement: column j = col + 2, row = j / 3, lane = j % 3
    logic [7:0]        chr_j;
    logic [13:0]       chr_prod;
    logic [4:0]        chr_grp;
    logic [1:0]        chr_lane;
    logic [TXT_AW-1:0] line_base;
    logic [TXT_AW-1:0] chr_addr;
    logic              line_in_range;
    logic              chr_in_range;

    assign chr_j         = {1'b0, r_col} + 8'd2;
    assign chr_prod      = 14'(chr_j * RECIP3);
    assign chr_grp       = chr_prod[11:7];
    assign chr_lane      = 2'(chr_j - 8'(8'(chr_grp) * 8'd3));
    assign line_base     = TXT_AW'(r_line * GROUPS);
    assign chr_addr      = line_base + TXT_AW'(chr_grp);
    assign line_in_range = {1'b0, r_line} < LINE_LIMIT;
    assign chr_in_range  = line_in_range && ({1'b0, r_col} < COL_LIMIT);

    // Clear pass after reset: fill every row with spaces
    logic              r_clearing;
    logic [TXT_AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == TXT_AW'(TXT_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Frame word counter and row read
    logic [WORD_W-1:0] r_word;
    logic              rd_en;
    logic [TXT_AW-1:0] rd_addr;

    assign rd_en   = i_cmd.word_load && (r_word != '0) && (r_word <= WORD_W'(GROUPS));
    assign rd_addr = line_base + TXT_AW'(r_word - 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.flush_start) begin
            r_word <= '0;
        end else if (i_cmd.word_load) begin
            r_word <= r_word + 1'b1;
        end
    end

    // Text store, one memory per byte lane
    logic [7:0] r_rd [LANES];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [7:0] r_text [TXT_DEPTH];
        always_ff @(posedge i_clk) begin
            if (r_clearing) begin
                r_text[r_clr_addr] <= B_SPACE;
            end else if (i_cmd.chr_commit && chr_lane == 2'(g)) begin
                r_text[chr_addr] <= sanitize(r_char);
            end
            if (rd_en) begin
                r_rd[g] <= r_text[rd_addr];
            end
        end
    end

    // Dirty flag
    logic r_dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= 1'b1;
        end else if (i_cmd.chr_commit) begin
            r_dirty <= 1'b1;
        end else if (i_cmd.flush_start && r_line == LAST_LINE) begin
            r_dirty <= 1'b0;
        end
    end

    // Frame word select
    logic [31:0] frame_word;

    always_comb begin
        if (r_word == WORD_W'(0)) begin
            frame_word = pack4(B_SYSEX, B_START, B_MAKER, B_MODEL);
        end else if (r_word == WORD_W'(1)) begin
            frame_word = pack4(B_SYSEX, B_MSG_ID, B_LINE_BASE + 8'(r_line), B_ZERO);
        end else if (r_word == WORD_W'(2)) begin
            frame_word = pack4(B_SYSEX, B_LEN, B_ZERO, r_rd[2]);
        end else if (r_word == WORD_W'(FLUSH_WORDS - 1)) begin
            frame_word = pack4(B_SYSEX_END, r_rd[0], B_END, B_SPACE);
        end else begin
            frame_word = pack4(B_SYSEX, r_rd[0], r_rd[1], r_rd[2]);
        end
    end

    // Output register
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        r_out_last;
    logic        out_free;

    assign out_free = !r_out_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pad_load || i_cmd.word_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pad_load) begin
            r_out_data <= pack4(r_status, r_blink, {2'b00, r_pad} + B_PAD_BASE, color_m);
            r_out_last <= 1'b1;
        end else if (i_cmd.word_load) begin
            r_out_data <= frame_word;
            r_out_last <= (r_word == WORD_W'(FLUSH_WORDS - 1));
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;
    assign o_m_last  = r_out_last;

    // Status
    always_comb begin
        o_stat.clearing  = r_clearing;
        o_stat.req_kind  = t_req'(r_type);
        o_stat.pad_emit  = pad_in_range && !pad_same;
        o_stat.chr_ok    = chr_in_range;
        o_stat.flush_ok  = line_in_range && r_dirty;
        o_stat.out_free  = out_free;
        o_stat.word_last = (r_word == WORD_W'(FLUSH_WORDS - 1));
    end

    // Checks
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> !r_clearing)
        else $error("request taken during text clear pass");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pad_load || i_cmd.word_load) |-> out_free)
        else $error("output register overwritten while holding a word");

    a_pad_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pad_load |=> r_sent_valid[$past(pad_idx)])
        else $error("pad not marked as sent after its word");

endmodule

[hdl/pad_delta_text_packetizer.sv]
// ----------------------------------------------------------------------------
// pad_delta_text_packetizer: pad LED and display text packetizer
// Sends a 32-bit word when a pad's color, blink or status changes, keeps a
// 4 x 68 character display and streams one line as a 26-word frame.
//
//   port group   dir  content
//   s_axis_*     in   requests: tuser = kind, tdata = pad and text fields
//   m_axis_*     out  packet words, tlast on the final word of a request
//   p*           in   register port: clear_code at address 0
//
//   Pad update: the request is registered on accept, decided in the execute
//   state and loaded into the output register once it is free. Character
//   write: stored in the execute state that follows accept. Line flush: the
//   first word is loaded in the flush state, then one frame word per cycle
//   while m_axis is not stalled (26 words) from the three-lane text store,
//   one row read a cycle. After reset the text store is filled with spaces
//   while s_axis_tready stays low. Requests are taken only when idle.
//   A stall on m_axis holds the output register and freezes the sequence.
// ----------------------------------------------------------------------------
module pad_delta_text_packetizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // pad_index[5:0], pad_color[13:6],
                                       // pad_blink[21:14], pad_status[29:22],
                                       // text_line[31:30], text_column[38:32],
                                       // text_char[46:39], zero[47]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    // packet stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // packet_word[31:0]
    output logic        m_axis_tlast,  // last_word
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pdtp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Register port
    logic [7:0] r_clear_code;
    logic       reg_sel;

    assign reg_sel = (paddr[2] == REG_CLEAR_CODE);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {24'd0, r_clear_code} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_code <= B_ERASE;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_clear_code <= pwdata[7:0];
        end
    end

    pdtp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    pdtp_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_clear_code  (r_clear_code),
        .i_req_type    (s_axis_tuser),
        .i_pad_index   (s_axis_tdata[5:0]),
        .i_pad_color   (s_axis_tdata[13:6]),
        .i_pad_blink   (s_axis_tdata[21:14]),
        .i_pad_status  (s_axis_tdata[29:22]),
        .i_text_line   (s_axis_tdata[31:30]),
        .i_text_column (s_axis_tdata[38:32]),
        .i_text_char   (s_axis_tdata[46:39]),
        .i_m_ready     (m_axis_tready),
        .o_m_valid     (m_axis_tvalid),
        .o_m_data      (m_axis_tdata),
        .o_m_last      (m_axis_tlast)
    );

endmodule
